// ===== sv/fcrt_pkg.sv =====
package fcrt_pkg;

    localparam int FLOOR_COUNT = 32;
    localparam int FLOOR_W     = (FLOOR_COUNT > 1) ? $clog2(FLOOR_COUNT) : 1;
    localparam int ENTRY_W     = 11;

    localparam logic [FLOOR_W-1:0] LAST_IDX      = FLOOR_W'(FLOOR_COUNT - 1);
    localparam logic [7:0]         FLOOR_COUNT_B = 8'(FLOOR_COUNT);

    localparam logic [1:0] CMD_RADIO  = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    localparam logic [7:0] CODE_UP    = 8'h01;
    localparam logic [7:0] CODE_DOWN  = 8'h02;
    localparam logic [7:0] CODE_LOAD  = 8'h03;
    localparam logic [7:0] CODE_CLEAR = 8'h20;

    localparam logic [2:0] FLAG_LOAD       = 3'b100;
    localparam logic [7:0] STATUS_POSITION = 8'h80;
    localparam logic [7:0] RSSI_RESET      = 8'h88;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_ELEVATOR  = 1'b1;

    typedef struct packed {
        logic [1:0]        command;
        logic              frame_ok;
        logic [7:0]        target_floor;
        logic [7:0]        message_code;
        logic [7:0]        message_id;
        logic signed [7:0] signal_rssi;
        logic [7:0]        clear_mask;
    } fcrt_item_t;

    typedef struct packed {
        logic              ack_send;
        logic [7:0]        reply_floor;
        logic [7:0]        ack_message_id;
        logic [7:0]        report_status;
        logic signed [7:0] report_rssi;
        logic [31:0]       packet_count;
        logic              floor_rejected;
    } fcrt_result_t;

    typedef struct packed {
        logic signed [7:0] threshold;
        logic [7:0]        car_floor;
    } fcrt_cfg_t;

endpackage

// ===== sv/fcrt_ram.sv =====
module fcrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/fcrt_regs.sv =====
module fcrt_regs
    import fcrt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output fcrt_cfg_t   cfg
);

    fcrt_cfg_t cfg_reg;
    logic      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= -8'sd50;
            cfg_reg.car_floor <= 8'd1;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_THRESHOLD: cfg_reg.threshold <= $signed(pwdata[7:0]);
                REG_ELEVATOR:  cfg_reg.car_floor <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_THRESHOLD: prdata = {24'd0, cfg_reg.threshold};
            REG_ELEVATOR:  prdata = {24'd0, cfg_reg.car_floor};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ===== sv/floor_call_register_table.sv =====
// Rejected or bad frames report from idle; radio packets and display clears do one
// read-modify-write of the entry; a proximity tick sweeps every floor; a display read
// scans on from the last reported floor. One item at a time; the next item can start
// as the result shows. busy covers the sweep or read-modify-write, one entry per cycle.
// Result shows on result for one cycle with done; the receiver cannot stall.
// Reset clears all flags and sets all strengths to -120 at once via per-floor valid bits.
module floor_call_register_table
    import fcrt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  fcrt_item_t   item,
    output logic         done,
    output fcrt_result_t result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RMW  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    fcrt_cfg_t cfg;

    logic [1:0]             state_reg, state_next;
    fcrt_item_t             item_reg, item_next;
    logic [FLOOR_W-1:0]     idx_reg;
    logic [FLOOR_W-1:0]     chk_reg, chk_next;
    logic                   rdv_reg;
    logic [FLOOR_COUNT-1:0] valid_reg;
    logic [7:0]             last_rep_reg, last_rep_next;
    logic [31:0]            count_reg, count_next;
    logic                   done_reg;
    fcrt_result_t           result_reg;

    logic                   ram_we;
    logic [FLOOR_W-1:0]     ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

    logic [2:0]             ent_flags;
    logic signed [7:0]      ent_rssi;
    logic                   produce;
    fcrt_result_t           res;
    logic                   tf_valid;
    logic [FLOOR_W-1:0]     tidx, start_idx, scan_next;
    logic                   is_call;
    logic [2:0]             call_bit;

    fcrt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcrt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FLOOR_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // never-written entries read as the reset contents
    assign ent_flags = rdv_reg ? ram_rdata[ENTRY_W-1:8] : 3'b000;
    assign ent_rssi  = rdv_reg ? $signed(ram_rdata[7:0]) : $signed(RSSI_RESET);

    assign tf_valid  = (item.target_floor != 8'd0) && (item.target_floor <= FLOOR_COUNT_B);
    assign tidx      = FLOOR_W'(item.target_floor - 8'd1);
    assign start_idx = (last_rep_reg >= FLOOR_COUNT_B) ? '0 : FLOOR_W'(last_rep_reg);
    assign scan_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    assign is_call  = (item_reg.message_code == CODE_UP) ||
                      (item_reg.message_code == CODE_DOWN) ||
                      (item_reg.message_code == CODE_LOAD);
    assign call_bit = (item_reg.message_code == CODE_LOAD) ? FLAG_LOAD
                                                           : item_reg.message_code[2:0];

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        chk_next      = chk_reg;
        last_rep_next = last_rep_reg;
        count_next    = count_reg;
        ram_raddr     = idx_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg;
        ram_wdata     = {ent_flags, ent_rssi};
        produce       = 1'b0;
        res           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    case (item.command)
                        CMD_RADIO, CMD_CANCEL:
                        begin
                            if (item.command == CMD_RADIO && item.frame_ok)
                            begin
                                count_next = count_reg + 32'd1;
                            end
                            if (item.frame_ok && tf_valid)
                            begin
                                ram_raddr  = tidx;
                                state_next = S_RMW;
                            end
                            else
                            begin
                                produce            = 1'b1;
                                res.floor_rejected = item.frame_ok;
                            end
                        end
                        default:
                        begin
                            ram_raddr  = start_idx;
                            chk_next   = '0;
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            S_RMW:
            begin
                ram_we     = 1'b1;
                produce    = 1'b1;
                state_next = S_IDLE;
                if (item_reg.command == CMD_RADIO)
                begin
                    ram_wdata = {ent_flags | (is_call ? call_bit : 3'b000),
                                 item_reg.signal_rssi};
                    if (is_call)
                    begin
                        res.ack_send       = 1'b1;
                        res.reply_floor    = item_reg.target_floor;
                        res.ack_message_id = item_reg.message_id;
                    end
                end
                else if (item_reg.message_code == CODE_CLEAR)
                begin
                    ram_wdata = {ent_flags & ~item_reg.clear_mask[2:0], ent_rssi};
                end
            end

            S_SCAN:
            begin
                ram_raddr = scan_next;
                chk_next  = chk_reg + 1'b1;
                if (item_reg.command == CMD_TICK)
                begin
                    if (ent_flags != 3'b000 && ent_rssi > cfg.threshold)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {3'b000, ent_rssi};
                    end
                    if (chk_reg == LAST_IDX)
                    begin
                        produce    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (ent_flags != 3'b000)
                begin
                    produce           = 1'b1;
                    state_next        = S_IDLE;
                    res.reply_floor   = 8'(idx_reg) + 8'd1;
                    res.report_status = {5'd0, ent_flags};
                    res.report_rssi   = ent_rssi;
                    last_rep_next     = 8'(idx_reg) + 8'd1;
                end
                else if (chk_reg == LAST_IDX)
                begin
                    produce           = 1'b1;
                    state_next        = S_IDLE;
                    res.reply_floor   = cfg.car_floor;
                    res.report_status = STATUS_POSITION;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.packet_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            last_rep_reg <= 8'd0;
            count_reg    <= 32'd0;
            done_reg     <= 1'b0;
            rdv_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_rep_reg <= last_rep_next;
            count_reg    <= count_next;
            done_reg     <= produce;
            rdv_reg      <= valid_reg[ram_raddr];
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        idx_reg  <= ram_raddr;
        chk_reg  <= chk_next;
        if (produce)
        begin
            result_reg <= res;
        end
    end

endmodule

// ===== sv/fcrt_checker.sv =====
module fcrt_checker
    import fcrt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input fcrt_result_t result
);

    // every accepted item either starts work or reports next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor done");

    // an idle cycle with no accept leaves nothing to report
    a_no_spurious_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("result without pending item");

    a_ack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.ack_send) |->
            (result.report_status == 8'd0 && !result.floor_rejected))
        else $error("ack mixed with report or reject");

    a_position_report: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.report_status[7]) |->
            (result.report_rssi == 8'sd0 && result.report_status[6:0] == 7'd0))
        else $error("position report carries floor data");

endmodule

bind floor_call_register_table fcrt_checker u_fcrt_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
